// File: rtl/ffrp_pkg.sv
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared types and constants for the FASTQ/FASTA record parser.
// ----------------------------------------------------------------------------
package ffrp_pkg;

	typedef enum logic [2:0] {
		KIND_NAME    = 3'd0,
		KIND_COMMENT = 3'd1,
		KIND_SEQ     = 3'd2,
		KIND_QUAL    = 3'd3,
		KIND_DONE    = 3'd4,
		KIND_BAD     = 3'd5,
		KIND_END     = 3'd6
	} kind_t;

	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;

	localparam int MAX_RES = 3;
	localparam int QDEPTH  = 4;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [31:0] record_length;
	} result_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	function automatic bundle_t push_result(bundle_t b, kind_t k, logic [7:0] c,
			logic [31:0] len);
		bundle_t r;
		r = b;
		if (b.cnt != 2'(MAX_RES)) begin
			r.res[b.cnt].kind          = k;
			r.res[b.cnt].out_byte      = c;
			r.res[b.cnt].record_length = len;
			r.cnt                      = b.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

// File: rtl/ffrp_if.sv
// ----------------------------------------------------------------------------
// ffrp_if
// Valid/ready channels for input bytes and tagged results.
// ----------------------------------------------------------------------------
interface ffrp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface ffrp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [31:0] record_length;
	logic        last_of_run;

	modport source (output valid, output kind, output out_byte, output record_length,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input out_byte, input record_length,
		input last_of_run, output ready);
endinterface

// File: rtl/ffrp_front.sv
// ----------------------------------------------------------------------------
// ffrp_front
// Parser state machine: classifies each byte and builds its result bundle.
// ----------------------------------------------------------------------------
module ffrp_front import ffrp_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	ffrp_in_if.sink bytes,
	input  logic    full,
	output logic    push,
	output bundle_t push_data
);

	localparam int EXT_BITS = (LEN_BITS > 32) ? LEN_BITS : 32;

	typedef enum logic [6:0] {
		PH_SEEK      = 7'b0000001,
		PH_NAME      = 7'b0000010,
		PH_COMMENT   = 7'b0000100,
		PH_SEQ_START = 7'b0001000,
		PH_SEQ_LINE  = 7'b0010000,
		PH_PLUS      = 7'b0100000,
		PH_QUAL      = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic                held_cr;
		logic                has_content;
		logic [LEN_BITS-1:0] seq_cnt;
		logic [LEN_BITS-1:0] qual_cnt;
		logic                err;
	} pstate_t;

	typedef struct packed {
		pstate_t s;
		bundle_t b;
	} work_t;

	pstate_t st_q;
	work_t   w;
	logic    take;

	function automatic logic [LEN_BITS-1:0] sat_inc(logic [LEN_BITS-1:0] v);
		return (&v) ? v : v + LEN_BITS'(1);
	endfunction

	function automatic logic [31:0] len32(logic [LEN_BITS-1:0] v);
		logic [EXT_BITS-1:0] e;
		e = EXT_BITS'(v);
		return (e > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c inside {CH_SP, [CH_TAB:CH_CR]};
	endfunction

	function automatic work_t emit_field(work_t x, kind_t k, logic [7:0] c);
		work_t r;
		r = x;
		if (k == KIND_SEQ) r.s.seq_cnt = sat_inc(x.s.seq_cnt);
		if (k == KIND_QUAL) r.s.qual_cnt = sat_inc(x.s.qual_cnt);
		r.b = push_result(x.b, k, c, 32'd0);
		return r;
	endfunction

	function automatic work_t line_byte(work_t x, kind_t k, logic [7:0] c);
		work_t r;
		r = x;
		if (r.s.held_cr) begin
			r = emit_field(r, k, CH_CR);
			r.s.has_content = 1'b1;
		end
		if (c == CH_CR) begin
			r.s.held_cr = 1'b1;
		end else begin
			r.s.held_cr = 1'b0;
			r = emit_field(r, k, c);
			r.s.has_content = 1'b1;
		end
		return r;
	endfunction

	function automatic work_t line_end(work_t x, kind_t k);
		work_t r;
		r = x;
		if (r.s.held_cr && !r.s.has_content) r = emit_field(r, k, CH_CR);
		r.s.held_cr     = 1'b0;
		r.s.has_content = 1'b0;
		return r;
	endfunction

	function automatic work_t clear_record(work_t x);
		work_t r;
		r = x;
		r.s.seq_cnt     = '0;
		r.s.qual_cnt    = '0;
		r.s.held_cr     = 1'b0;
		r.s.has_content = 1'b0;
		return r;
	endfunction

	function automatic work_t record_done(work_t x);
		work_t r;
		r = x;
		r.b = push_result(x.b, KIND_DONE, 8'd0, len32(x.s.seq_cnt));
		return r;
	endfunction

	function automatic work_t malformed(work_t x);
		work_t r;
		r = x;
		r.b = push_result(x.b, KIND_BAD, 8'd0, 32'd0);
		r.s.err = 1'b1;
		return r;
	endfunction

	function automatic work_t quality_check(work_t x, logic eos);
		work_t r;
		r = x;
		if (r.s.qual_cnt == r.s.seq_cnt) begin
			r = record_done(r);
			if (eos) r.b = push_result(r.b, KIND_END, 8'd0, 32'd0);
			r = clear_record(r);
			r.s.phase = PH_SEEK;
		end else begin
			r = malformed(r);
		end
		return r;
	endfunction

	always_comb begin
		logic       fin;
		logic [7:0] c;
		fin    = 1'b1;
		c      = bytes.data_byte;
		w.s    = st_q;
		w.b    = '0;
		if (!st_q.err) begin
			if (bytes.cmd) begin
				case (st_q.phase)
					PH_NAME, PH_SEQ_START: begin
						w = record_done(w);
					end
					PH_COMMENT: begin
						w = line_end(w, KIND_COMMENT);
						w = record_done(w);
					end
					PH_SEQ_LINE: begin
						w = line_end(w, KIND_SEQ);
						w = record_done(w);
					end
					PH_PLUS: begin
						w   = malformed(w);
						fin = 1'b0;
					end
					PH_QUAL: begin
						w   = line_end(w, KIND_QUAL);
						w   = quality_check(w, 1'b1);
						fin = 1'b0;
					end
					default: ;
				endcase
				if (fin) begin
					w.b       = push_result(w.b, KIND_END, 8'd0, 32'd0);
					w         = clear_record(w);
					w.s.phase = PH_SEEK;
				end
			end else begin
				case (st_q.phase)
					PH_NAME: begin
						if (c == CH_LF) w.s.phase = PH_SEQ_START;
						else if (is_ws(c)) w.s.phase = PH_COMMENT;
						else w = emit_field(w, KIND_NAME, c);
					end
					PH_COMMENT: begin
						if (c == CH_LF) begin
							w         = line_end(w, KIND_COMMENT);
							w.s.phase = PH_SEQ_START;
						end else begin
							w = line_byte(w, KIND_COMMENT, c);
						end
					end
					PH_SEQ_START: begin
						if (c inside {CH_GT, CH_AT}) begin
							w         = record_done(w);
							w         = clear_record(w);
							w.s.phase = PH_NAME;
						end else if (c == CH_PLUS) begin
							w.s.phase = PH_PLUS;
						end else if (c != CH_LF) begin
							w.s.phase = PH_SEQ_LINE;
							w         = line_byte(w, KIND_SEQ, c);
						end
					end
					PH_SEQ_LINE: begin
						if (c == CH_LF) begin
							w         = line_end(w, KIND_SEQ);
							w.s.phase = PH_SEQ_START;
						end else begin
							w = line_byte(w, KIND_SEQ, c);
						end
					end
					PH_PLUS: begin
						if (c == CH_LF) begin
							w.s.held_cr     = 1'b0;
							w.s.has_content = 1'b0;
							w.s.phase       = PH_QUAL;
						end
					end
					PH_QUAL: begin
						if (c == CH_LF) begin
							w = line_end(w, KIND_QUAL);
							if (w.s.qual_cnt >= w.s.seq_cnt) w = quality_check(w, 1'b0);
						end else begin
							w = line_byte(w, KIND_QUAL, c);
						end
					end
					default: begin
						if (c inside {CH_GT, CH_AT}) begin
							w         = clear_record(w);
							w.s.phase = PH_NAME;
						end else begin
							w.s.phase = PH_SEEK;
						end
					end
				endcase
			end
		end
	end

	assign bytes.ready = !full;
	assign take        = bytes.valid && !full;
	assign push        = take && (w.b.cnt != 2'd0);
	assign push_data   = w.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_SEEK;
			st_q.held_cr     <= 1'b0;
			st_q.has_content <= 1'b0;
			st_q.seq_cnt     <= '0;
			st_q.qual_cnt    <= '0;
			st_q.err         <= 1'b0;
		end else if (take) begin
			st_q <= w.s;
		end
	end

endmodule

// File: rtl/ffrp_queue.sv
// ----------------------------------------------------------------------------
// ffrp_queue
// Short FIFO of result bundles between the parser and the output side.
// ----------------------------------------------------------------------------
module ffrp_queue import ffrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    empty,
	output bundle_t head
);

	localparam int PTR_W = $clog2(QDEPTH);

	bundle_t          mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PTR_W'(1);
			if (do_pop) rd_q <= rd_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/ffrp_back.sv
// ----------------------------------------------------------------------------
// ffrp_back
// Walks the head bundle and presents its results one transfer at a time.
// ----------------------------------------------------------------------------
module ffrp_back import ffrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        empty,
	output logic        pop,
	ffrp_out_if.source  results
);

	logic [1:0] idx_q;
	logic       last;
	logic       xfer;
	result_t    cur;

	assign cur                   = head.res[idx_q];
	assign last                  = (idx_q == head.cnt - 2'd1);
	assign results.valid         = !empty;
	assign results.kind          = cur.kind;
	assign results.out_byte      = cur.out_byte;
	assign results.record_length = cur.record_length;
	assign results.last_of_run   = last;
	assign xfer                  = results.valid && results.ready;
	assign pop                   = xfer && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/fastq_fasta_record_parser.sv
// ----------------------------------------------------------------------------
// fastq_fasta_record_parser
// Results are registered in the queue, then offered. Throughput: one byte per
// cycle unless the queue is full; output moves one result per cycle when ready,
// so a byte with k results holds it for k transfers; a 4-entry bundle queue
// lets input run ahead. Reset: arst_n clears parser state and queue.
// ----------------------------------------------------------------------------
module fastq_fasta_record_parser import ffrp_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ffrp_in_if.sink    bytes,
	ffrp_out_if.source results
);

	logic    push;
	bundle_t push_data;
	logic    full;
	logic    empty;
	logic    pop;
	bundle_t head;

	ffrp_front #(.LEN_BITS(LEN_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	ffrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	ffrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

endmodule

// File: rtl/ffrp_checker.sv
// ----------------------------------------------------------------------------
// ffrp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ffrp_checker import ffrp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  kind,
	input logic [7:0]  out_byte,
	input logic [31:0] record_length,
	input logic        last_of_run
);

	// marker results carry no byte
	a_marker_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_DONE || kind == KIND_BAD || kind == KIND_END)
		|-> out_byte == 8'd0)
		else $error("marker result with nonzero byte");

	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind != KIND_DONE |-> record_length == 32'd0)
		else $error("length on a result other than record done");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_BAD || kind == KIND_END) |-> last_of_run)
		else $error("stream end or malformed not last of run");

	// nothing follows a malformed result
	a_bad_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && kind == KIND_BAD |=> !valid)
		else $error("result after malformed");

endmodule

bind fastq_fasta_record_parser ffrp_checker u_ffrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (results.valid),
	.ready         (results.ready),
	.kind          (results.kind),
	.out_byte      (results.out_byte),
	.record_length (results.record_length),
	.last_of_run   (results.last_of_run)
);

// File: tb/fastq_fasta_record_parser_checker.sv
// ----------------------------------------------------------------------------
// fastq_fasta_record_parser_checker
// Watches the byte and result channels of the record parser. Each accepted
// byte or end-of-stream transfer runs through a parser model kept here, which
// queues the tagged results it should cause. Each accepted result is compared
// with the oldest queued one; the failure count and the number of results
// still outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module fastq_fasta_record_parser_checker import ffrp_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	ffrp_in_if   bytes,
	ffrp_out_if  results,
	output int   failures,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_NAME,
		PH_COMMENT,
		PH_SEQ_START,
		PH_SEQ_LINE,
		PH_PLUS,
		PH_QUAL
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag_byte;
		logic [31:0] rec_len;
		logic        last;
	} field_tag_t;

	localparam longint unsigned LEN_SAT = (64'd1 << LEN_BITS) - 64'd1;

	phase_t          phase;
	bit              held_cr;
	bit              line_content;
	bit              err_seen;
	longint unsigned seq_len;
	longint unsigned qual_total;
	field_tag_t      tag_fifo[$];
	field_tag_t      run_tags[$];

	function automatic void add_tag(kind_t k, logic [7:0] b, longint unsigned len);
		field_tag_t t;
		if (run_tags.size() < MAX_RES) begin
			t.kind     = k;
			t.tag_byte = b;
			t.rec_len  = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
			t.last     = 1'b0;
			run_tags.push_back(t);
		end
	endfunction

	function automatic void count_field(kind_t k, logic [7:0] c);
		if (k == KIND_SEQ && seq_len < LEN_SAT) seq_len++;
		if (k == KIND_QUAL && qual_total < LEN_SAT) qual_total++;
		add_tag(k, c, 0);
	endfunction

	// CR is held until we know whether it ends the line
	function automatic void content_byte(kind_t k, logic [7:0] c);
		if (held_cr) begin
			count_field(k, CH_CR);
			line_content = 1'b1;
		end
		if (c == CH_CR) begin
			held_cr = 1'b1;
		end else begin
			held_cr = 1'b0;
			count_field(k, c);
			line_content = 1'b1;
		end
	endfunction

	function automatic void close_line(kind_t k);
		if (held_cr && !line_content) count_field(k, CH_CR);
		held_cr      = 1'b0;
		line_content = 1'b0;
	endfunction

	function automatic void clear_record();
		seq_len      = 0;
		qual_total   = 0;
		held_cr      = 1'b0;
		line_content = 1'b0;
	endfunction

	function automatic void flag_bad();
		add_tag(KIND_BAD, 8'h00, 0);
		err_seen = 1'b1;
	endfunction

	function automatic void settle_quality(bit at_eos);
		if (qual_total == seq_len) begin
			add_tag(KIND_DONE, 8'h00, seq_len);
			if (at_eos) add_tag(KIND_END, 8'h00, 0);
			clear_record();
			phase = PH_SEEK;
		end else begin
			flag_bad();
		end
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void predict_transfer(logic eos, logic [7:0] c);
		bit finish;
		finish = 1'b1;
		run_tags.delete();
		if (err_seen) return;
		if (eos) begin
			case (phase)
				PH_NAME, PH_SEQ_START: add_tag(KIND_DONE, 8'h00, seq_len);
				PH_COMMENT: begin
					close_line(KIND_COMMENT);
					add_tag(KIND_DONE, 8'h00, seq_len);
				end
				PH_SEQ_LINE: begin
					close_line(KIND_SEQ);
					add_tag(KIND_DONE, 8'h00, seq_len);
				end
				PH_PLUS: begin
					flag_bad();
					finish = 1'b0;
				end
				PH_QUAL: begin
					close_line(KIND_QUAL);
					settle_quality(1'b1);
					finish = 1'b0;
				end
				default: ;
			endcase
			if (finish) begin
				add_tag(KIND_END, 8'h00, 0);
				clear_record();
				phase = PH_SEEK;
			end
		end else begin
			case (phase)
				PH_NAME:
					if (c == CH_LF) phase = PH_SEQ_START;
					else if (is_space(c)) phase = PH_COMMENT;
					else count_field(KIND_NAME, c);
				PH_COMMENT:
					if (c == CH_LF) begin
						close_line(KIND_COMMENT);
						phase = PH_SEQ_START;
					end else begin
						content_byte(KIND_COMMENT, c);
					end
				PH_SEQ_START:
					if (c == CH_GT || c == CH_AT) begin
						add_tag(KIND_DONE, 8'h00, seq_len);
						clear_record();
						phase = PH_NAME;
					end else if (c == CH_PLUS) begin
						phase = PH_PLUS;
					end else if (c != CH_LF) begin
						phase = PH_SEQ_LINE;
						content_byte(KIND_SEQ, c);
					end
				PH_SEQ_LINE:
					if (c == CH_LF) begin
						close_line(KIND_SEQ);
						phase = PH_SEQ_START;
					end else begin
						content_byte(KIND_SEQ, c);
					end
				PH_PLUS:
					if (c == CH_LF) begin
						held_cr      = 1'b0;
						line_content = 1'b0;
						phase        = PH_QUAL;
					end
				PH_QUAL:
					if (c == CH_LF) begin
						close_line(KIND_QUAL);
						if (qual_total >= seq_len) settle_quality(1'b0);
					end else begin
						content_byte(KIND_QUAL, c);
					end
				default:
					if (c == CH_GT || c == CH_AT) begin
						clear_record();
						phase = PH_NAME;
					end
			endcase
		end
		if (run_tags.size() > 0) run_tags[run_tags.size() - 1].last = 1'b1;
		foreach (run_tags[i]) tag_fifo.push_back(run_tags[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_tag_t want;
		if (!arst_n) begin
			phase    = PH_SEEK;
			err_seen = 1'b0;
			clear_record();
			tag_fifo.delete();
			failures = 0;
			pending  = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (tag_fifo.size() == 0) begin
					failures++;
					$display("%0t: unexpected result kind=%0d byte=%02h len=%0d last=%0b",
						$time, results.kind, results.out_byte, results.record_length,
						results.last_of_run);
				end else begin
					want = tag_fifo.pop_front();
					if (results.kind !== want.kind || results.out_byte !== want.tag_byte ||
							results.record_length !== want.rec_len ||
							results.last_of_run !== want.last) begin
						failures++;
						$display({"%0t: mismatch: expected kind=%0d byte=%02h len=%0d last=%0b,",
							" actual kind=%0d byte=%02h len=%0d last=%0b"}, $time,
							want.kind, want.tag_byte, want.rec_len, want.last,
							results.kind, results.out_byte, results.record_length,
							results.last_of_run);
					end
				end
			end
			if (bytes.valid && bytes.ready) predict_transfer(bytes.cmd, bytes.data_byte);
			pending = tag_fifo.size();
		end
	end

endmodule

// File: tb/fastq_fasta_record_parser_tb.sv
// ----------------------------------------------------------------------------
// fastq_fasta_record_parser_tb
// Stimulus and verdict for the FASTQ/FASTA record parser. A short directed
// stream covers whitespace, CR handling, empty lines and end of stream in the
// parser's phases; then random well-formed records with random content, mixed
// with truncated records and skipped noise, run under four sender/receiver
// idle settings. A single malformed record closes the run, since the error
// holds until reset. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module fastq_fasta_record_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffrp_pkg::*;

	typedef logic [7:0] octet_q_t[$];

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] SEP_BYTES[5] = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
	localparam int RANDOM_ITEMS = 340;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   pending;
	int   src_idle_pct;
	int   sink_stall_pct;
	int   items_sent;
	bit   hold_off;
	bit   at_seek;

	ffrp_in_if  bytes_if();
	ffrp_out_if results_if();

	fastq_fasta_record_parser #(.LEN_BITS(32)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.results (results_if)
	);

	fastq_fasta_record_parser_checker #(.LEN_BITS(32)) tag_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes_if),
		.results  (results_if),
		.failures (failures),
		.pending  (pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		results_if.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_item(input logic eos, input logic [7:0] b, input bit counted);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			bytes_if.valid     <= 1'b0;
			bytes_if.data_byte <= 8'($urandom);
			@(negedge clk);
		end
		bytes_if.valid     <= 1'b1;
		bytes_if.cmd       <= eos;
		bytes_if.data_byte <= b;
		do @(posedge clk); while (!bytes_if.ready);
		@(negedge clk);
		if (counted) items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b, 1'b1);
	endtask

	task automatic send_eos();
		send_item(1'b1, 8'($urandom), 1'b1);
		at_seek = 1'b1;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_line(input octet_q_t line);
		foreach (line[i]) send_byte(line[i]);
	endtask

	task automatic wait_drained();
		bytes_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] name_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_SP || (b >= CH_TAB && b <= CH_CR));
		return b;
	endfunction

	function automatic logic [7:0] comment_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_GT || b == CH_AT);
		return b;
	endfunction

	// line whose counted length is exactly k: a trailing CR after content is dropped,
	// a CR inside the line or alone on it counts
	function automatic octet_q_t make_line(int k, bit seq_line);
		octet_q_t line;
		if (k == 1 && $urandom_range(7) == 0) line.push_back(CH_CR);
		else for (int i = 0; i < k; i++) line.push_back(plain_byte());
		if (k > 1 && $urandom_range(5) == 0) line[$urandom_range(k - 2)] = CH_CR;
		if (seq_line && k > 0 && (line[0] == CH_GT || line[0] == CH_AT || line[0] == CH_PLUS))
			line[0] = 8'h41;
		if (k > 0 && $urandom_range(4) == 0) line.push_back(CH_CR);
		return line;
	endfunction

	task automatic send_random_record();
		int       pick;
		int       n_seq;
		int       n_lines;
		int       k;
		int       rem;
		bit       eos_end;
		octet_q_t line;
		pick    = $urandom_range(99);
		eos_end = ($urandom_range(3) == 0);
		if (at_seek && pick < 8) begin
			repeat ($urandom_range(1, 4)) send_item(1'b0, noise_byte(), 1'b0);
			return;
		end
		send_byte($urandom_range(1) ? CH_GT : CH_AT);
		at_seek = 1'b0;
		repeat ($urandom_range(0, 6)) send_byte(name_byte());
		if ($urandom_range(2) == 0) begin
			send_byte(SEP_BYTES[$urandom_range(4)]);
			repeat ($urandom_range(0, 5)) send_byte(comment_byte());
		end
		if (pick < 16) begin
			send_eos();
			return;
		end
		send_byte(CH_LF);
		n_seq   = 0;
		n_lines = $urandom_range(0, 3);
		for (int i = 0; i < n_lines; i++) begin
			k    = $urandom_range(0, 5);
			line = make_line(k, 1'b1);
			send_line(line);
			n_seq += k;
			if (!(pick < 45 && eos_end && i == n_lines - 1) || $urandom_range(1))
				send_byte(CH_LF);
		end
		if (pick < 45) begin
			if (eos_end) send_eos();
			return;
		end
		send_byte(CH_PLUS);
		repeat ($urandom_range(0, 3)) send_byte(comment_byte());
		send_byte(CH_LF);
		rem = n_seq;
		do begin
			k    = (rem == 0 || $urandom_range(7) == 0) ? 0 : $urandom_range(1, rem);
			line = make_line(k, 1'b0);
			send_line(line);
			rem -= k;
			if (rem == 0 && eos_end) send_eos();
			else send_byte(CH_LF);
		end while (rem > 0);
		at_seek = 1'b1;
	endtask

	initial begin
		int goal;
		int wait_cycles;
		bytes_if.valid     = 1'b0;
		bytes_if.cmd       = 1'b0;
		bytes_if.data_byte = 8'h00;
		results_if.ready   = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		hold_off           = 1'b0;
		items_sent         = 0;
		at_seek            = 1'b1;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: stream end while seeking, skipped bytes, full FASTQ record
		send_eos();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("@");
		send_byte(8'hFF);
		send_text("\tx");
		send_byte(CH_CR);
		send_text("y");
		send_byte(CH_CR);
		send_text("\n\n");
		send_byte(8'h00);
		send_byte(CH_CR);
		send_text("\n");
		send_byte(CH_CR);
		send_text("\n+z\n@>\n");
		send_text(">");
		send_byte(CH_VT);
		send_text("q");
		send_eos();
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 49;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 49;
				end
				default: begin
					src_idle_pct   = 7;
					sink_stall_pct = 7;
				end
			endcase
			goal = items_sent + RANDOM_ITEMS / 4;
			if (ph == 0) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (80) @(negedge clk);
						hold_off = 1'b0;
					end
					repeat (3) send_random_record();
				join
			end
			while (items_sent < goal) send_random_record();
			if (!at_seek) send_eos();
			wait_drained();
		end

		// malformed record last: the error holds until reset
		send_text("@r\nAC\n+\n");
		case ($urandom_range(2))
			0: send_eos();
			1: send_text("ACG\n");
			default: begin
				send_text("A");
				send_eos();
			end
		endcase
		send_text(">x\nA\n");
		send_eos();
		bytes_if.valid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 2000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (10) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
